// ----- src/tlb_pkg.sv -----
// ----------------------------------------------------------------------------
// tlb_pkg
// Shared defaults for the fully associative translation buffer.
// ----------------------------------------------------------------------------
package tlb_pkg;

	localparam int unsigned ENTRIES_DEF     = 16;
	localparam int unsigned PAGE_WIDTH_DEF  = 8;
	localparam int unsigned FRAME_WIDTH_DEF = 8;

endpackage

// ----- src/tlb_lru_lookup.sv -----
// ----------------------------------------------------------------------------
// tlb_lru_lookup
// Fully associative translation buffer with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A lookup is taken on any cycle with start high; busy is always low, so one
// lookup may be issued every cycle. Its result appears on frame_number,
// tlb_hit and slot_used for exactly one cycle, marked by done; the receiver
// cannot stall it and must take every transfer. A lookup passes the input
// register, then the output and frame store read registers; the tag compare,
// age matrix and victim choice all settle in the cycle between them. Empty
// entries fill in order; once full, the least recently used entry is replaced.
// ----------------------------------------------------------------------------
module tlb_lru_lookup
	import tlb_pkg::*;
#(
	parameter int unsigned ENTRIES     = ENTRIES_DEF,
	parameter int unsigned PAGE_WIDTH  = PAGE_WIDTH_DEF,
	parameter int unsigned FRAME_WIDTH = FRAME_WIDTH_DEF,
	localparam int unsigned SLOT_W     = $clog2(ENTRIES)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [PAGE_WIDTH-1:0]  page_number,
	input  logic [FRAME_WIDTH-1:0] walk_frame,
	output logic                   done,
	output logic [FRAME_WIDTH-1:0] frame_number,
	output logic                   tlb_hit,
	output logic [SLOT_W-1:0]      slot_used
);

	logic                   valid_s1;
	logic [PAGE_WIDTH-1:0]  page_s1;
	logic [FRAME_WIDTH-1:0] walk_s1;

	logic                   valid_s2;
	logic                   hit_s2;
	logic [SLOT_W-1:0]      slot_s2;
	logic [FRAME_WIDTH-1:0] walk_s2;

	logic                   hit;
	logic [SLOT_W-1:0]      hit_idx;
	logic                   full;
	logic [SLOT_W-1:0]      fill_idx;
	logic [SLOT_W-1:0]      victim_idx;
	logic [SLOT_W-1:0]      slot;
	logic                   install;
	logic [FRAME_WIDTH-1:0] ram_rdata;

	assign busy    = 1'b0;
	assign slot    = hit ? hit_idx : (full ? victim_idx : fill_idx);
	assign install = valid_s1 && !hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			page_s1 <= page_number;
			walk_s1 <= walk_frame;
		end
		if (valid_s1) begin
			hit_s2  <= hit;
			slot_s2 <= slot;
			walk_s2 <= walk_s1;
		end
	end

	tlb_tag_cam #(
		.ENTRIES    (ENTRIES),
		.PAGE_WIDTH (PAGE_WIDTH)
	) u_cam (
		.clk         (clk),
		.arst_n      (arst_n),
		.lookup_page (page_s1),
		.write_en    (install),
		.write_idx   (slot),
		.hit         (hit),
		.hit_idx     (hit_idx),
		.full        (full),
		.fill_idx    (fill_idx)
	);

	tlb_lru_matrix #(
		.ENTRIES (ENTRIES)
	) u_lru (
		.clk        (clk),
		.arst_n     (arst_n),
		.touch_en   (valid_s1),
		.touch_idx  (slot),
		.victim_idx (victim_idx)
	);

	tlb_frame_ram #(
		.ENTRIES     (ENTRIES),
		.FRAME_WIDTH (FRAME_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (install),
		.rd_en   (valid_s1 && hit),
		.addr    (slot),
		.wr_data (walk_s1),
		.rd_data (ram_rdata)
	);

	assign done         = valid_s2;
	assign tlb_hit      = hit_s2;
	assign slot_used    = slot_s2;
	assign frame_number = hit_s2 ? ram_rdata : walk_s2;

endmodule

// ----- src/tlb_tag_cam.sv -----
// ----------------------------------------------------------------------------
// tlb_tag_cam
// Page tag store with parallel compare and in-order fill pointer.
// ----------------------------------------------------------------------------
module tlb_tag_cam
	import tlb_pkg::*;
#(
	parameter int unsigned ENTRIES    = ENTRIES_DEF,
	parameter int unsigned PAGE_WIDTH = PAGE_WIDTH_DEF,
	localparam int unsigned SLOT_W    = $clog2(ENTRIES)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [PAGE_WIDTH-1:0] lookup_page,
	input  logic                  write_en,
	input  logic [SLOT_W-1:0]     write_idx,
	output logic                  hit,
	output logic [SLOT_W-1:0]     hit_idx,
	output logic                  full,
	output logic [SLOT_W-1:0]     fill_idx
);

	logic [PAGE_WIDTH-1:0] tag_q [ENTRIES];
	logic [SLOT_W:0]       fill_q;
	logic [ENTRIES-1:0]    match;

	assign full     = (fill_q == (SLOT_W+1)'(ENTRIES));
	assign fill_idx = fill_q[SLOT_W-1:0];

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = ((SLOT_W+1)'(i) < fill_q) && (tag_q[i] == lookup_page);
			if (match[i])
				hit_idx = hit_idx | SLOT_W'(i);
		end
		hit = |match;
	end

	always_ff @(posedge clk) begin
		if (write_en)
			tag_q[write_idx] <= lookup_page;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (write_en && !full) begin
			fill_q <= fill_q + 1'b1;
		end
	end

endmodule

// ----- src/tlb_lru_matrix.sv -----
// ----------------------------------------------------------------------------
// tlb_lru_matrix
// Age matrix for least-recently-used victim selection.
// ----------------------------------------------------------------------------
module tlb_lru_matrix
	import tlb_pkg::*;
#(
	parameter int unsigned ENTRIES = ENTRIES_DEF,
	localparam int unsigned SLOT_W = $clog2(ENTRIES)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              touch_en,
	input  logic [SLOT_W-1:0] touch_idx,
	output logic [SLOT_W-1:0] victim_idx
);

	// row i bit j set: entry i used more recently than entry j
	logic [ENTRIES-1:0] age_q [ENTRIES];
	logic [ENTRIES-1:0] oldest;

	always_comb begin
		victim_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			oldest[i] = (age_q[i] == '0);
			if (oldest[i])
				victim_idx = victim_idx | SLOT_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++)
				age_q[i] <= '0;
		end else if (touch_en) begin
			for (int i = 0; i < ENTRIES; i++) begin
				for (int j = 0; j < ENTRIES; j++) begin
					if (SLOT_W'(i) == touch_idx)
						age_q[i][j] <= (SLOT_W'(j) != touch_idx);
					else if (SLOT_W'(j) == touch_idx)
						age_q[i][j] <= 1'b0;
				end
			end
		end
	end

endmodule

// ----- src/tlb_frame_ram.sv -----
// ----------------------------------------------------------------------------
// tlb_frame_ram
// Frame store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module tlb_frame_ram
	import tlb_pkg::*;
#(
	parameter int unsigned ENTRIES     = ENTRIES_DEF,
	parameter int unsigned FRAME_WIDTH = FRAME_WIDTH_DEF,
	localparam int unsigned SLOT_W     = $clog2(ENTRIES)
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic                   rd_en,
	input  logic [SLOT_W-1:0]      addr,
	input  logic [FRAME_WIDTH-1:0] wr_data,
	output logic [FRAME_WIDTH-1:0] rd_data
);

	logic [FRAME_WIDTH-1:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[addr];
	end

endmodule
